>>> hdl/wlc_pkg.sv
// Shared types, constants and helper functions of the window lifter controller.
// No dependencies; the config registers, the core and the top level use this package.
package wlc_pkg;

	localparam int LEVELS   = 10;
	localparam int BAR_BITS = 10;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 16;
	localparam int DIV_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PRESCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PRESCALE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_THRESHOLD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_PERIOD      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PINCH_HOLD       = 3'd5;

	localparam logic [1:0] MODE_MANUAL  = 2'd0;
	localparam logic [1:0] MODE_AUTO    = 2'd1;
	localparam logic [1:0] MODE_STANDBY = 2'd2;
	localparam logic [1:0] MODE_PINCH   = 2'd3;

	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_OPEN  = 2'd1;
	localparam logic [1:0] DIR_CLOSE = 2'd2;

	// lamp vector: bit 0 open lamp, bit 1 close lamp
	localparam logic [1:0] LAMP_OFF   = 2'b00;
	localparam logic [1:0] LAMP_OPEN  = 2'b01;
	localparam logic [1:0] LAMP_CLOSE = 2'b10;

	typedef struct packed {
		logic [DIV_W-1:0] control_prescale;
		logic [DIV_W-1:0] sample_prescale;
		logic [CNT_W-1:0] auto_threshold;
		logic [CNT_W-1:0] manual_threshold;
		logic [CNT_W-1:0] move_period;
		logic [CNT_W-1:0] pinch_hold;
	} cfg_t;

	typedef struct packed {
		logic open_button;
		logic close_button;
		logic pinch_button;
	} btn_t;

	typedef struct packed {
		logic [POS_W-1:0]    position;
		logic [BAR_BITS-1:0] bar_leds;
		logic [1:0]          mode;
		logic [1:0]          direction;
		logic [1:0]          lamps;
	} rsl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

>>> hdl/wlc_btn_if.sv
// Request channel carrying the three button levels of one base tick.
// Depends on nothing.
interface wlc_btn_if;
	logic valid;
	logic ready;
	logic open_button;
	logic close_button;
	logic pinch_button;

	modport source (output valid, output open_button, output close_button,
		output pinch_button, input ready);
	modport sink (input valid, input open_button, input close_button,
		input pinch_button, output ready);
endinterface

>>> hdl/wlc_status_if.sv
// Result channel carrying window position, LED bar, mode, direction and lamps.
// Depends on nothing.
interface wlc_status_if;
	logic       valid;
	logic       ready;
	logic [3:0] position;
	logic [9:0] bar_leds;
	logic [1:0] mode;
	logic [1:0] direction;
	logic       open_lamp;
	logic       close_lamp;

	modport source (output valid, output position, output bar_leds, output mode,
		output direction, output open_lamp, output close_lamp, input ready);
	modport sink (input valid, input position, input bar_leds, input mode,
		input direction, input open_lamp, input close_lamp, output ready);
endinterface

>>> hdl/wlc_cfg_regs.sv
// Configuration register file: prescalers, mode thresholds, move period, pinch hold.
// Depends on wlc_pkg.
module wlc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [wlc_pkg::CFG_IDX_W-1:0]     index,
	input  logic [wlc_pkg::CFG_DATA_W-1:0]    data,
	output wlc_pkg::cfg_t                     cfg
);

	wlc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_prescale <= 8'd2;
			cfg_q.sample_prescale  <= 8'd5;
			cfg_q.auto_threshold   <= 16'd10;
			cfg_q.manual_threshold <= 16'd500;
			cfg_q.move_period      <= 16'd400;
			cfg_q.pinch_hold       <= 16'd5000;
		end else if (we) begin
			unique case (index)
				wlc_pkg::REG_CONTROL_PRESCALE: cfg_q.control_prescale <= data[7:0];
				wlc_pkg::REG_SAMPLE_PRESCALE:  cfg_q.sample_prescale  <= data[7:0];
				wlc_pkg::REG_AUTO_THRESHOLD:   cfg_q.auto_threshold   <= data;
				wlc_pkg::REG_MANUAL_THRESHOLD: cfg_q.manual_threshold <= data;
				wlc_pkg::REG_MOVE_PERIOD:      cfg_q.move_period      <= data;
				wlc_pkg::REG_PINCH_HOLD:       cfg_q.pinch_hold       <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/wlc_ctrl_core.sv
// Controller state and its one-tick update: prescalers, button sample, hold
// counting, mode selection, anti-pinch reversal and position stepping. Uses wlc_pkg.
module wlc_ctrl_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  wlc_pkg::btn_t btn,
	input  wlc_pkg::cfg_t cfg,
	output wlc_pkg::rsl_t nxt
);

	logic [wlc_pkg::DIV_W-1:0]    cdiv_q, sdiv_q;
	logic                         seen_q;
	logic [wlc_pkg::CNT_W-1:0]    hold_q, move_q, pinch_q;
	logic [1:0]                   mode_q, dir_q, lamp_q;
	logic [wlc_pkg::POS_W-1:0]    pos_q;
	logic [wlc_pkg::BAR_BITS-1:0] bar_q;

	logic [wlc_pkg::DIV_W-1:0]    cdiv_inc, sdiv_inc, cdiv_d, sdiv_d;
	logic                         ctick, stick, seen_d;
	logic [wlc_pkg::CNT_W-1:0]    hold_d, move_d, pinch_d, move_inc;
	logic [1:0]                   mode_d, dir_d, lamp_d;
	logic [wlc_pkg::POS_W-1:0]    pos_d;
	logic [wlc_pkg::BAR_BITS-1:0] bar_d, bar_bit;
	logic                         do_bar, do_step;

	assign cdiv_inc = cdiv_q + wlc_pkg::DIV_W'(1);
	assign sdiv_inc = sdiv_q + wlc_pkg::DIV_W'(1);
	assign ctick    = (cdiv_inc == cfg.control_prescale);
	assign stick    = (sdiv_inc == cfg.sample_prescale);
	assign cdiv_d   = ctick ? '0 : cdiv_inc;
	assign sdiv_d   = stick ? '0 : sdiv_inc;
	assign seen_d   = stick ? (btn.open_button | btn.close_button | btn.pinch_button)
		: seen_q;
	assign move_inc = wlc_pkg::sat_inc(move_q);
	assign bar_bit  = wlc_pkg::BAR_BITS'(1) << (pos_q - wlc_pkg::POS_W'(1));

	always_comb begin
		hold_d  = hold_q;
		move_d  = move_q;
		pinch_d = pinch_q;
		mode_d  = mode_q;
		dir_d   = dir_q;
		lamp_d  = lamp_q;
		pos_d   = pos_q;
		bar_d   = bar_q;
		do_bar  = 1'b0;
		do_step = 1'b0;
		if (ctick) begin
			move_d = move_inc;
			if (mode_q != wlc_pkg::MODE_PINCH && seen_q) begin
				if (btn.open_button) begin
					hold_d = wlc_pkg::sat_inc(hold_q);
					dir_d  = wlc_pkg::DIR_OPEN;
					lamp_d = wlc_pkg::LAMP_OPEN;
				end else if (btn.close_button) begin
					hold_d = wlc_pkg::sat_inc(hold_q);
					dir_d  = wlc_pkg::DIR_CLOSE;
					lamp_d = wlc_pkg::LAMP_CLOSE;
				end else if (btn.pinch_button) begin
					if (dir_q == wlc_pkg::DIR_CLOSE) begin
						hold_d  = '0;
						pinch_d = '0;
						mode_d  = wlc_pkg::MODE_PINCH;
						dir_d   = wlc_pkg::DIR_OPEN;
						lamp_d  = wlc_pkg::LAMP_OPEN;
					end
				end else begin
					hold_d = '0;
				end
			end
			if (mode_d == wlc_pkg::MODE_PINCH) begin
				pinch_d = wlc_pkg::sat_inc(pinch_d);
			end else if (hold_d >= cfg.auto_threshold && hold_d < cfg.manual_threshold) begin
				mode_d = wlc_pkg::MODE_AUTO;
			end else if (hold_d >= cfg.manual_threshold) begin
				mode_d = wlc_pkg::MODE_MANUAL;
				lamp_d = wlc_pkg::LAMP_OFF;
			end
			if (move_inc >= cfg.move_period) begin
				move_d = '0;
				case (mode_d)
					wlc_pkg::MODE_MANUAL: begin
						do_bar = 1'b1;
						if (seen_q) do_step = 1'b1;
						else mode_d = wlc_pkg::MODE_STANDBY;
					end
					wlc_pkg::MODE_AUTO: begin
						do_bar  = 1'b1;
						do_step = 1'b1;
					end
					wlc_pkg::MODE_PINCH: begin
						do_bar  = 1'b1;
						do_step = 1'b1;
						if (pinch_d >= cfg.pinch_hold) mode_d = wlc_pkg::MODE_STANDBY;
					end
					default: ;
				endcase
				// bar bit exists only for levels 1 .. BAR_BITS
				if (do_bar && pos_q >= wlc_pkg::POS_W'(1)
						&& pos_q <= wlc_pkg::POS_W'(wlc_pkg::BAR_BITS)) begin
					if (dir_d == wlc_pkg::DIR_OPEN) bar_d = bar_q & ~bar_bit;
					else if (dir_d == wlc_pkg::DIR_CLOSE) bar_d = bar_q | bar_bit;
				end
				if (do_step) begin
					if (dir_d == wlc_pkg::DIR_OPEN) begin
						if (pos_q < wlc_pkg::POS_W'(wlc_pkg::LEVELS))
							pos_d = pos_q + wlc_pkg::POS_W'(1);
						else
							lamp_d = wlc_pkg::LAMP_OFF;
					end else if (dir_d == wlc_pkg::DIR_CLOSE) begin
						if (pos_q > wlc_pkg::POS_W'(1))
							pos_d = pos_q - wlc_pkg::POS_W'(1);
						else
							lamp_d = wlc_pkg::LAMP_OFF;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cdiv_q  <= '0;
			sdiv_q  <= '0;
			seen_q  <= 1'b0;
			hold_q  <= '0;
			move_q  <= '0;
			pinch_q <= '0;
			mode_q  <= wlc_pkg::MODE_STANDBY;
			dir_q   <= wlc_pkg::DIR_NONE;
			lamp_q  <= wlc_pkg::LAMP_OFF;
			pos_q   <= wlc_pkg::POS_W'(1);
			bar_q   <= '0;
		end else if (en) begin
			cdiv_q  <= cdiv_d;
			sdiv_q  <= sdiv_d;
			seen_q  <= seen_d;
			hold_q  <= hold_d;
			move_q  <= move_d;
			pinch_q <= pinch_d;
			mode_q  <= mode_d;
			dir_q   <= dir_d;
			lamp_q  <= lamp_d;
			pos_q   <= pos_d;
			bar_q   <= bar_d;
		end
	end

	assign nxt.position  = pos_d;
	assign nxt.bar_leds  = bar_d;
	assign nxt.mode      = mode_d;
	assign nxt.direction = dir_d;
	assign nxt.lamps     = lamp_d;

endmodule

>>> hdl/window_lifter_controller_unit.sv
// Window lifter controller with anti-pinch reversal, top level.
// Usage:
//   buttons : one request per base tick with the open, close and pinch levels.
//   status  : one result per request: position, LED bar, mode, direction, lamps.
//   cfg_we/cfg_index/cfg_data : register writes, only while the block is idle.
// Path: an accepted request is taken into the input register, then the state update
// is written into the result register, from which the result is shown on status.
// Throughput: one request per clock unless the pipe stalls; the state update is
// combinational compare and counter logic in the core.
// Stall: when status is valid and not taken, the whole pipe holds and
// buttons.ready drops; nothing is lost or repeated.
// Reset: arst_n clears both pipe stages and puts the controller in standby,
// position 1, bar and lamps off, registers at their defaults.
// Depends on wlc_pkg, wlc_btn_if, wlc_status_if, wlc_cfg_regs, wlc_ctrl_core.
module window_lifter_controller_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	wlc_btn_if.sink                        buttons,
	wlc_status_if.source                   status,
	input  logic                           cfg_we,
	input  logic [wlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wlc_pkg::CFG_DATA_W-1:0] cfg_data
);

	wlc_pkg::cfg_t cfg;
	wlc_pkg::btn_t btn_s1;
	wlc_pkg::rsl_t nxt, rsl_s2;
	logic          vld_s1, vld_s2, adv;

	assign adv           = !vld_s2 || status.ready;
	assign buttons.ready = adv;

	wlc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	wlc_ctrl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (vld_s1 && adv),
		.btn    (btn_s1),
		.cfg    (cfg),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= buttons.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			btn_s1.open_button  <= buttons.open_button;
			btn_s1.close_button <= buttons.close_button;
			btn_s1.pinch_button <= buttons.pinch_button;
			rsl_s2              <= nxt;
		end
	end

	assign status.valid      = vld_s2;
	assign status.position   = rsl_s2.position;
	assign status.bar_leds   = rsl_s2.bar_leds;
	assign status.mode       = rsl_s2.mode;
	assign status.direction  = rsl_s2.direction;
	assign status.open_lamp  = rsl_s2.lamps[0];
	assign status.close_lamp = rsl_s2.lamps[1];

endmodule
